/* rtl/hse_pkg.sv */
// Shared data type and sequencer state codes for the heap sort engine.
`timescale 1ns / 1ps

package hse_pkg;

  // Element width.
  localparam int DATA_W = 32;

  typedef logic [DATA_W-1:0] data_t;

  // Sequencer state codes.
  localparam int ST_W = 4;

  typedef logic [ST_W-1:0] state_t;

  localparam state_t ST_IDLE     = 4'd0;
  localparam state_t ST_BLD_RD   = 4'd1;
  localparam state_t ST_BLD_LD   = 4'd2;
  localparam state_t ST_SIFT_C1  = 4'd3;
  localparam state_t ST_SIFT_C2  = 4'd4;
  localparam state_t ST_SIFT_CMP = 4'd5;
  localparam state_t ST_EXT_RD0  = 4'd6;
  localparam state_t ST_EXT_RD1  = 4'd7;
  localparam state_t ST_EXT_WR   = 4'd8;
  localparam state_t ST_FIN_RD0  = 4'd9;
  localparam state_t ST_FIN_RD1  = 4'd10;
  localparam state_t ST_FIN_CMP  = 4'd11;
  localparam state_t ST_FIN_WR   = 4'd12;
  localparam state_t ST_EMIT     = 4'd13;

endpackage

/* rtl/hse_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/heap_sort_engine.sv */
// Heap sort engine: loads a set into RAM, heap-sorts it in place and streams it out.
// Load: one beat per cycle while busy is low; the beat with in_last_in starts the sort.
// Sort: each sift-down level reads and compares both children on the single RAM read port
//   (SIFT_C1, SIFT_C2, SIFT_CMP); each extraction adds EXT_RD0, EXT_RD1 and EXT_WR.
// Emit: N result beats on consecutive cycles, each registered from an emit-state RAM read;
//   results cannot be stalled. busy stays high from the last load beat to the final read.
// Reset clears the fill count, the drop flag and the sequencer; the RAM is not cleared.
`timescale 1ns / 1ps

module heap_sort_engine #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [hse_pkg::DATA_W-1:0] in_value,
  input  logic                      in_last_in,
  output logic                      out_strobe,
  output logic [hse_pkg::DATA_W-1:0] out_sorted_value,
  output logic                      out_last_out,
  output logic                      out_overflow
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  // Sequencer and bookkeeping registers.
  hse_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            drop_r, drop_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic            build_r, build_nxt;
  logic [AW-1:0]   p_r, p_nxt;
  logic [CW-1:0]   sz_r, sz_nxt;
  hse_pkg::data_t  v_r, v_nxt;
  hse_pkg::data_t  a_r, a_nxt;
  logic            has2_r, has2_nxt;
  logic [AW-1:0]   k_r, k_nxt;
  logic            strobe_r, strobe_nxt;
  logic            last_r, last_nxt;
  logic            ovf_r, ovf_nxt;

  // RAM port.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  hse_pkg::data_t  ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  hse_pkg::data_t  ram_rdata;

  // Derived values.
  logic            accept;
  logic [CW-1:0]   fill_inc;
  logic [IW-1:0]   c1;
  logic [IW-1:0]   c2;
  logic [IW-1:0]   sz_ext;
  logic            pick_c2;
  logic [IW-1:0]   big_idx;
  hse_pkg::data_t  big_val;
  logic [CW-1:0]   ext_i;
  hse_pkg::state_t after_sift;
  logic            emit_last;

  hse_ram #(
    .WIDTH (hse_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state_r != hse_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign fill_inc = fill_r + CW'(1);

  // Child indexes of the current node, widened so that 2p+2 never wraps.
  assign c1      = {1'b0, p_r, 1'b1};
  assign c2      = c1 + IW'(1);
  assign sz_ext  = IW'(sz_r);
  assign pick_c2 = has2_r && !(a_r > ram_rdata);
  assign big_idx = pick_c2 ? c2 : c1;
  assign big_val = pick_c2 ? ram_rdata : a_r;

  // Next extraction index once a sift-down finishes.
  assign ext_i = build_r ? (n_r - CW'(1)) : (i_r - CW'(1));

  always_comb begin
    if (build_r && (i_r > CW'(1))) begin
      after_sift = hse_pkg::ST_BLD_RD;
    end else if (ext_i > CW'(1)) begin
      after_sift = hse_pkg::ST_EXT_RD0;
    end else begin
      after_sift = hse_pkg::ST_FIN_RD0;
    end
  end

  assign emit_last = (CW'(k_r) == (n_r - CW'(1)));

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    drop_nxt   = drop_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    build_nxt  = build_r;
    p_nxt      = p_r;
    sz_nxt     = sz_r;
    v_nxt      = v_r;
    a_nxt      = a_r;
    has2_nxt   = has2_r;
    k_nxt      = k_r;
    strobe_nxt = 1'b0;
    last_nxt   = 1'b0;
    ovf_nxt    = ovf_r;
    ram_we     = 1'b0;
    ram_waddr  = p_r;
    ram_wdata  = v_r;
    ram_re     = 1'b0;
    ram_raddr  = p_r;

    case (state_r)
      hse_pkg::ST_IDLE: begin
        if (accept) begin
          // Store the beat, or drop it once the RAM is full.
          if (fill_r < CW'(DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[AW-1:0];
            ram_wdata = in_value;
            fill_nxt  = fill_inc;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_in) begin
            n_nxt     = fill_nxt;
            i_nxt     = fill_nxt >> 1;
            build_nxt = 1'b1;
            if (fill_nxt < CW'(2)) begin
              state_nxt = hse_pkg::ST_EMIT;
            end else begin
              state_nxt = hse_pkg::ST_BLD_RD;
            end
          end
        end
      end

      // Heap build: sift down from node i-1 over the whole set.
      hse_pkg::ST_BLD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(i_r - CW'(1));
        p_nxt     = AW'(i_r - CW'(1));
        sz_nxt    = n_r;
        state_nxt = hse_pkg::ST_BLD_LD;
      end

      hse_pkg::ST_BLD_LD: begin
        v_nxt     = ram_rdata;
        state_nxt = hse_pkg::ST_SIFT_C1;
      end

      // Sift-down with a hole: v is the value travelling down from node p.
      hse_pkg::ST_SIFT_C1: begin
        if (c1 >= sz_ext) begin
          ram_we    = 1'b1;
          ram_waddr = p_r;
          ram_wdata = v_r;
          i_nxt     = build_r ? (i_r - CW'(1)) : ext_i;
          if (build_r && (i_r <= CW'(1))) begin
            build_nxt = 1'b0;
            i_nxt     = ext_i;
          end
          state_nxt = after_sift;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = c1[AW-1:0];
          state_nxt = hse_pkg::ST_SIFT_C2;
        end
      end

      hse_pkg::ST_SIFT_C2: begin
        a_nxt    = ram_rdata;
        has2_nxt = (c2 < sz_ext);
        if (c2 < sz_ext) begin
          ram_re    = 1'b1;
          ram_raddr = c2[AW-1:0];
        end
        state_nxt = hse_pkg::ST_SIFT_CMP;
      end

      hse_pkg::ST_SIFT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = p_r;
        if (v_r > big_val) begin
          ram_wdata = v_r;
          i_nxt     = build_r ? (i_r - CW'(1)) : ext_i;
          if (build_r && (i_r <= CW'(1))) begin
            build_nxt = 1'b0;
            i_nxt     = ext_i;
          end
          state_nxt = after_sift;
        end else begin
          ram_wdata = big_val;
          p_nxt     = big_idx[AW-1:0];
          state_nxt = hse_pkg::ST_SIFT_C1;
        end
      end

      // Extraction: the tail value becomes the hole value, the root moves to the tail.
      hse_pkg::ST_EXT_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = i_r[AW-1:0];
        state_nxt = hse_pkg::ST_EXT_RD1;
      end

      hse_pkg::ST_EXT_RD1: begin
        v_nxt     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = hse_pkg::ST_EXT_WR;
      end

      hse_pkg::ST_EXT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = ram_rdata;
        p_nxt     = '0;
        sz_nxt    = i_r;
        state_nxt = hse_pkg::ST_SIFT_C1;
      end

      // Final compare and swap of the first two entries.
      hse_pkg::ST_FIN_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = hse_pkg::ST_FIN_RD1;
      end

      hse_pkg::ST_FIN_RD1: begin
        a_nxt     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = AW'(1);
        state_nxt = hse_pkg::ST_FIN_CMP;
      end

      hse_pkg::ST_FIN_CMP: begin
        if (a_r > ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = ram_rdata;
          state_nxt = hse_pkg::ST_FIN_WR;
        end else begin
          state_nxt = hse_pkg::ST_EMIT;
        end
      end

      hse_pkg::ST_FIN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(1);
        ram_wdata = a_r;
        state_nxt = hse_pkg::ST_EMIT;
      end

      // Stream the sorted set out, one read per cycle.
      hse_pkg::ST_EMIT: begin
        ram_re     = 1'b1;
        ram_raddr  = k_r;
        strobe_nxt = 1'b1;
        last_nxt   = emit_last;
        ovf_nxt    = drop_r;
        if (emit_last) begin
          k_nxt     = '0;
          fill_nxt  = '0;
          drop_nxt  = 1'b0;
          state_nxt = hse_pkg::ST_IDLE;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end

      default: begin
        state_nxt = hse_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hse_pkg::ST_IDLE;
      fill_r   <= '0;
      drop_r   <= 1'b0;
      build_r  <= 1'b0;
      k_r      <= '0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      drop_r   <= drop_nxt;
      build_r  <= build_nxt;
      k_r      <= k_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    p_r    <= p_nxt;
    sz_r   <= sz_nxt;
    v_r    <= v_nxt;
    a_r    <= a_nxt;
    has2_r <= has2_nxt;
    ovf_r  <= ovf_nxt;
  end

  // Result beat comes straight from the RAM read register.
  assign out_strobe       = strobe_r;
  assign out_sorted_value = ram_rdata;
  assign out_last_out     = last_r;
  assign out_overflow     = ovf_r;

  // A result beat only follows a read issued by the emit state.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == hse_pkg::ST_EMIT))
    else $error("result beat without an emit read");

  // No cycle both writes and reads the same RAM entry.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("RAM read and write collide on one entry");

  // The fill count never passes the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond capacity");

  // The last marker only rides on a result beat.
  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_out |-> out_strobe)
    else $error("last marker without a result beat");

  // After the final beat of a set the engine is idle and empty.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_out) |-> ($past(state_nxt) == hse_pkg::ST_IDLE))
    else $error("engine not idle after the final result beat");

endmodule

/* tb/heap_sort_checker.sv */
// Scoreboard for the heap sort engine: predicts each sorted set and checks every result beat.
`timescale 1ns / 1ps

module heap_sort_checker #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [hse_pkg::DATA_W-1:0] in_value,
  input  logic                       in_last_in,
  input  logic                       out_strobe,
  input  logic [hse_pkg::DATA_W-1:0] out_sorted_value,
  input  logic                       out_last_out,
  input  logic                       out_overflow,
  output int                         fail_count,
  output int                         pending
);

  // One predicted result beat.
  typedef struct {
    hse_pkg::data_t value;
    logic           last_out;
    logic           overflow;
  } sorted_beat_t;

  hse_pkg::data_t set_vals[$];   // values held for the set being loaded
  logic           set_dropped;   // a value of this set found the store full
  sorted_beat_t   sorted_q[$];   // result beats still to come, oldest first
  int             mismatches;
  int             outstanding;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic check_field(input string name, input logic [hse_pkg::DATA_W-1:0] want,
                             input logic [hse_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sorted_beat_t   want;
    hse_pkg::data_t ordered[$];
    if (!rst_n) begin
      set_vals.delete();
      sorted_q.delete();
      set_dropped = 1'b0;
      mismatches  = 0;
      outstanding = 0;
    end else begin
      // Compare an emitted beat with the oldest prediction.
      if (out_strobe) begin
        if (sorted_q.size() == 0) begin
          $error("sorted_value: expected no beat, got %h", out_sorted_value);
          mismatches++;
        end else begin
          want = sorted_q.pop_front();
          check_field("sorted_value", want.value, out_sorted_value);
          check_field("last_out", hse_pkg::data_t'(want.last_out),
                      hse_pkg::data_t'(out_last_out));
          check_field("overflow", hse_pkg::data_t'(want.overflow),
                      hse_pkg::data_t'(out_overflow));
        end
      end

      // Store an accepted beat; the closing beat of a set yields the sorted set.
      if (start && !busy) begin
        if (set_vals.size() < DEPTH)
          set_vals.push_back(in_value);
        else
          set_dropped = 1'b1;
        if (in_last_in) begin
          ordered = set_vals;
          ordered.sort();
          foreach (ordered[k]) begin
            want.value    = ordered[k];
            want.last_out = (k == ordered.size() - 1);
            want.overflow = set_dropped;
            sorted_q.push_back(want);
          end
          set_vals.delete();
          set_dropped = 1'b0;
        end
      end
      outstanding = sorted_q.size();
    end
  end

endmodule

/* tb/tb_heap_sort_engine.sv */
// Testbench top for the heap sort engine: clock, reset, set stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_heap_sort_engine;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic           clk;
  logic           rst_n      = 1'b0;
  logic           start      = 1'b0;
  hse_pkg::data_t in_value   = '0;
  logic           in_last_in = 1'b0;
  logic           busy;
  logic           out_strobe;
  hse_pkg::data_t out_sorted_value;
  logic           out_last_out;
  logic           out_overflow;

  int   fail_count;
  int   pending;
  int   stall_cycles = 0;
  logic gaps_on      = 1'b1;

  heap_sort_engine #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

  heap_sort_checker #(.DEPTH(DEPTH)) sort_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: too long without any beat in either direction ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one beat, starting at a falling edge, with random gaps ahead of it.
  // Returns at the falling edge after the beat was taken, start still high.
  task automatic send_beat(input hse_pkg::data_t val, input logic last);
    logic taken;
    taken = 1'b0;
    while (gaps_on && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    in_value   <= val;
    in_last_in <= last;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  task automatic send_set(input hse_pkg::data_t vals[$]);
    foreach (vals[i])
      send_beat(vals[i], i == vals.size() - 1);
  endtask

  // Hold the sender off until every predicted beat has come out.
  task automatic wait_drained();
    start <= 1'b0;
    do
      @(negedge clk);
    while (pending != 0);
  endtask

  initial begin
    hse_pkg::data_t set_q[$];
    hse_pkg::data_t val;
    int             rand_items;
    int             set_idx;
    int             n;
    int             pick;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets: single values at both extremes, pairs in each order and tied,
    // extremes with duplicates, and a fully reversed run.
    set_q = {32'hFFFF_FFFF};
    send_set(set_q);
    set_q = {32'h0000_0000};
    send_set(set_q);
    set_q = {32'd7, 32'd3};
    send_set(set_q);
    set_q = {32'd3, 32'd7};
    send_set(set_q);
    set_q = {32'd9, 32'd9};
    send_set(set_q);
    set_q = {32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF};
    send_set(set_q);
    set_q = {32'd5, 32'd4, 32'd3, 32'd2, 32'd1, 32'd0};
    send_set(set_q);
    wait_drained();

    // Random sets: mostly short, some filling the store, a few running past it.
    rand_items = 0;
    set_idx    = 0;
    while (rand_items < RANDOM_ITEMS) begin
      gaps_on = !(rand_items >= 150 && rand_items < 260);
      pick = $urandom_range(99);
      if (set_idx == 0)
        n = DEPTH;
      else if (set_idx == 1)
        n = DEPTH + 2;
      else if (pick < 60)
        n = $urandom_range(8, 1);
      else if (pick < 85)
        n = $urandom_range(40, 9);
      else if (pick < 95)
        n = $urandom_range(DEPTH, 41);
      else
        n = $urandom_range(DEPTH + 8, DEPTH + 1);

      set_q.delete();
      repeat (n) begin
        case ($urandom_range(3))
          0, 1: val = $urandom;
          2:    val = $urandom_range(7);
          default: begin
            pick = $urandom_range(31);
            case ($urandom_range(3))
              0:       val = '0;
              1:       val = '1;
              2:       val = hse_pkg::data_t'(1) << pick;
              default: val = ~(hse_pkg::data_t'(1) << pick);
            endcase
          end
        endcase
        set_q.push_back(val);
      end
      send_set(set_q);
      rand_items += n;
      set_idx++;
      if ($urandom_range(5) == 0)
        wait_drained();
    end

    // Let the last set come out, then give stray beats time to show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
